[rtl/hws_pkg.sv]
`default_nettype none

package hws_pkg;

  localparam int GRID_W = 128;
  localparam int GRID_H = 128;
  localparam int CELLS  = GRID_W * GRID_H;

  localparam int COL_W = $clog2(GRID_W);
  localparam int ROW_W = $clog2(GRID_H);
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [15:0] DAMP_RESET = 16'd64881;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_KICK = 2'd1;
  localparam logic [1:0] ACT_STEP = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // clamp a 34-bit signed value into the Q16.16 range
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v[33:31] != {3{v[33]}}) begin
      r = v[33] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [33:0] sext34(input logic [31:0] v);
    return $signed({{2{v[31]}}, v});
  endfunction

endpackage

`default_nettype wire

[rtl/heightfield_wave_step_top.sv]
`default_nettype none

// Heightfield water ripple engine over a GRID_W x GRID_H grid of Q16.16 heights and
// velocities, kept in three on-chip memories (current height, next height, velocity).
// After reset a clearing pass zeroes all three memories, one entry per cycle, over all
// CELLS entries; no request is taken meanwhile, damping writes are. Add, kick and read
// requests read the addressed words in the cycle they are accepted, then hold the input
// through ST_POKE (kick, read) or ST_POKE and ST_POKE_NX (add, one adder pass per
// height store); a read holds longer while its result register is full and stalled. A
// step request walks each cell through ST_CELL_RD, ST_SUM_VD, ST_SUM_L, ST_SUM_R,
// ST_MEAN, ST_CTR, ST_MUL, ST_RND and ST_UPD, using a single 34-bit adder that sums the
// four neighbors, forms the new velocity, rounds the damped product and updates the
// next height, followed by a copy sweep of next height into current height at one word
// per cycle. The block takes one request at a time; a read result waits in an output
// register, so a following request is accepted while it is still pending.
module heightfield_wave_step_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [6:0]  in_col,
  input  wire logic [6:0]  in_row,
  input  wire logic [31:0] in_amount,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_height
);

  localparam int IW = hws_pkg::IDX_W;
  localparam int CW = hws_pkg::COL_W;
  localparam int RW = hws_pkg::ROW_W;
  localparam int NW = hws_pkg::CNT_W;

  typedef enum logic [13:0] {
    ST_CLEAR   = 14'b00_0000_0000_0001,
    ST_IDLE    = 14'b00_0000_0000_0010,
    ST_POKE    = 14'b00_0000_0000_0100,
    ST_POKE_NX = 14'b00_0000_0000_1000,
    ST_CELL_RD = 14'b00_0000_0001_0000,
    ST_SUM_VD  = 14'b00_0000_0010_0000,
    ST_SUM_L   = 14'b00_0000_0100_0000,
    ST_SUM_R   = 14'b00_0000_1000_0000,
    ST_MEAN    = 14'b00_0001_0000_0000,
    ST_CTR     = 14'b00_0010_0000_0000,
    ST_MUL     = 14'b00_0100_0000_0000,
    ST_RND     = 14'b00_1000_0000_0000,
    ST_UPD     = 14'b01_0000_0000_0000,
    ST_COPY    = 14'b10_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]        damp_r;
  logic [1:0]         act_r;
  logic [31:0]        amt_r;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      x_r, x_nxt;
  logic [RW-1:0]      y_r, y_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic               cp_pend_r;
  logic [IW-1:0]      cp_waddr_r;
  logic signed [33:0] acc_r;
  logic signed [48:0] prod_r;
  logic               out_valid_r;
  logic [31:0]        out_height_r;

  // memories and their registered read data
  logic [31:0] now_mem  [hws_pkg::CELLS];
  logic [31:0] next_mem [hws_pkg::CELLS];
  logic [31:0] vel_mem  [hws_pkg::CELLS];
  logic [31:0] now_qa_r, now_qb_r, next_q_r, vel_q_r;

  logic          now_we, next_we, vel_we;
  logic [IW-1:0] now_waddr, next_waddr, vel_waddr;
  logic [31:0]   now_wdata, next_wdata, vel_wdata;
  logic          now_rea, now_reb, next_re, vel_re;
  logic [IW-1:0] now_raddr_a, now_raddr_b, next_raddr, vel_raddr;

  logic          in_acc;
  logic [CW-1:0] in_col_c;
  logic [RW-1:0] in_row_c;
  logic [IW-1:0] in_idx;
  logic [IW-1:0] up_idx, dn_idx, lf_idx, rt_idx;
  logic          x_last, y_last, out_free;

  logic signed [33:0] add_a, add_b, add_sum;
  logic               add_cin;
  logic [31:0]        add_sat;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_height = out_height_r;
  assign out_free   = !out_valid_r || !out_stall;

  // clamp coordinates to the grid
  assign in_col_c = (int'(in_col) >= hws_pkg::GRID_W) ? CW'(hws_pkg::GRID_W - 1) : CW'(in_col);
  assign in_row_c = (int'(in_row) >= hws_pkg::GRID_H) ? RW'(hws_pkg::GRID_H - 1) : RW'(in_row);
  assign in_idx   = IW'(int'(in_row_c) * hws_pkg::GRID_W) + IW'(in_col_c);

  assign x_last = (x_r == CW'(hws_pkg::GRID_W - 1));
  assign y_last = (y_r == RW'(hws_pkg::GRID_H - 1));

  // edge neighbors fold back onto the cell itself
  assign up_idx = (y_r == '0) ? idx_r : idx_r - IW'(hws_pkg::GRID_W);
  assign dn_idx = y_last      ? idx_r : idx_r + IW'(hws_pkg::GRID_W);
  assign lf_idx = (x_r == '0) ? idx_r : idx_r - IW'(1);
  assign rt_idx = x_last      ? idx_r : idx_r + IW'(1);

  // shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state_r)
      ST_POKE: begin
        add_a = hws_pkg::sext34(now_qa_r);
        add_b = hws_pkg::sext34(amt_r);
      end
      ST_POKE_NX: begin
        add_a = hws_pkg::sext34(next_q_r);
        add_b = hws_pkg::sext34(amt_r);
      end
      ST_SUM_VD: begin
        add_a = hws_pkg::sext34(now_qa_r);
        add_b = hws_pkg::sext34(now_qb_r);
      end
      ST_SUM_L: begin
        add_a = acc_r;
        add_b = hws_pkg::sext34(now_qa_r);
      end
      ST_SUM_R: begin
        add_a = acc_r;
        add_b = hws_pkg::sext34(now_qb_r);
      end
      ST_MEAN: begin
        add_a = hws_pkg::sext34(vel_q_r);
        add_b = acc_r >>> 2;
      end
      ST_CTR: begin
        add_a   = acc_r;
        add_b   = ~hws_pkg::sext34(now_qa_r);
        add_cin = 1'b1;
      end
      ST_RND: begin
        add_a   = hws_pkg::sext34(prod_r[47:16]);
        add_cin = prod_r[15];
      end
      ST_UPD: begin
        add_a = hws_pkg::sext34(next_q_r);
        add_b = acc_r;
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_a + add_b + $signed({33'd0, add_cin});
  assign add_sat = hws_pkg::sat34(add_sum);

  // memory port control
  always_comb begin
    now_we      = 1'b0;
    next_we     = 1'b0;
    vel_we      = 1'b0;
    now_waddr   = idx_r;
    next_waddr  = idx_r;
    vel_waddr   = idx_r;
    now_wdata   = add_sat;
    next_wdata  = add_sat;
    vel_wdata   = acc_r[31:0];
    now_rea     = 1'b0;
    now_reb     = 1'b0;
    next_re     = 1'b0;
    vel_re      = 1'b0;
    now_raddr_a = idx_r;
    now_raddr_b = idx_r;
    next_raddr  = idx_r;
    vel_raddr   = idx_r;
    case (state_r)
      ST_CLEAR: begin
        now_we     = 1'b1;
        next_we    = 1'b1;
        vel_we     = 1'b1;
        now_waddr  = cnt_r[IW-1:0];
        next_waddr = cnt_r[IW-1:0];
        vel_waddr  = cnt_r[IW-1:0];
        now_wdata  = '0;
        next_wdata = '0;
        vel_wdata  = '0;
      end
      ST_IDLE: begin
        now_rea     = in_acc;
        next_re     = in_acc;
        now_raddr_a = in_idx;
        next_raddr  = in_idx;
      end
      ST_POKE: begin
        now_we = (act_r != hws_pkg::ACT_READ);
      end
      ST_POKE_NX: begin
        next_we = 1'b1;
      end
      ST_CELL_RD: begin
        now_rea     = 1'b1;
        now_reb     = 1'b1;
        next_re     = 1'b1;
        vel_re      = 1'b1;
        now_raddr_a = up_idx;
        now_raddr_b = dn_idx;
      end
      ST_SUM_VD: begin
        now_rea     = 1'b1;
        now_reb     = 1'b1;
        now_raddr_a = lf_idx;
        now_raddr_b = rt_idx;
      end
      ST_SUM_R: begin
        now_rea = 1'b1;
      end
      ST_UPD: begin
        vel_we  = 1'b1;
        next_we = 1'b1;
      end
      ST_COPY: begin
        next_re    = (cnt_r != NW'(hws_pkg::CELLS));
        next_raddr = cnt_r[IW-1:0];
        now_we     = cp_pend_r;
        now_waddr  = cp_waddr_r;
        now_wdata  = next_q_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (now_we) now_mem[now_waddr] <= now_wdata;
    if (now_rea) now_qa_r <= now_mem[now_raddr_a];
    if (now_reb) now_qb_r <= now_mem[now_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (next_re) next_q_r <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (vel_we) vel_mem[vel_waddr] <= vel_wdata;
    if (vel_re) vel_q_r <= vel_mem[vel_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(hws_pkg::CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          x_nxt = '0;
          y_nxt = '0;
          if (in_action == hws_pkg::ACT_STEP) begin
            idx_nxt   = '0;
            state_nxt = ST_CELL_RD;
          end else begin
            idx_nxt   = in_idx;
            state_nxt = ST_POKE;
          end
        end
      end
      ST_POKE: begin
        if (act_r == hws_pkg::ACT_READ) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (act_r == hws_pkg::ACT_ADD) begin
          state_nxt = ST_POKE_NX;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POKE_NX: state_nxt = ST_IDLE;
      ST_CELL_RD: state_nxt = ST_SUM_VD;
      ST_SUM_VD:  state_nxt = ST_SUM_L;
      ST_SUM_L:   state_nxt = ST_SUM_R;
      ST_SUM_R:   state_nxt = ST_MEAN;
      ST_MEAN:    state_nxt = ST_CTR;
      ST_CTR:     state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_RND;
      ST_RND:     state_nxt = ST_UPD;
      ST_UPD: begin
        if (x_last && y_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_COPY;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = ST_CELL_RD;
          if (x_last) begin
            x_nxt = '0;
            y_nxt = y_r + RW'(1);
          end else begin
            x_nxt = x_r + CW'(1);
          end
        end
      end
      ST_COPY: begin
        // last write drains in the cycle the counter reaches the end
        if (cnt_r == NW'(hws_pkg::CELLS)) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      damp_r      <= hws_pkg::DAMP_RESET;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cp_pend_r <= (state_r == ST_COPY) && (cnt_r != NW'(hws_pkg::CELLS));
      if (cfg_we) damp_r <= cfg_data;
      if (state_r == ST_POKE && act_r == hws_pkg::ACT_READ && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    cp_waddr_r <= cnt_r[IW-1:0];
    if (in_acc) begin
      act_r <= in_action;
      amt_r <= in_amount;
    end
    if (state_r == ST_SUM_VD || state_r == ST_SUM_L || state_r == ST_SUM_R ||
        state_r == ST_MEAN || state_r == ST_CTR || state_r == ST_RND) begin
      acc_r <= add_sum;
    end
    if (state_r == ST_MUL) begin
      prod_r <= $signed(hws_pkg::sat34(acc_r)) * $signed({1'b0, damp_r});
    end
    if (state_r == ST_POKE && act_r == hws_pkg::ACT_READ && out_free) begin
      out_height_r <= now_qa_r;
    end
  end

`ifndef SYNTHESIS
  a_cell_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CELL_RD |-> idx_r == IW'(int'(y_r) * hws_pkg::GRID_W + int'(x_r)))
    else $error("cell index out of step with its coordinates");

  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && $past(state_r) == ST_CLEAR) |->
      $past(cnt_r) == NW'(hws_pkg::CELLS - 1))
    else $error("clearing pass ended early");

  a_copy_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY && cnt_r == NW'(hws_pkg::CELLS)) |-> cp_pend_r)
    else $error("copy sweep ends without its last write");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_POKE && $past(act_r) == hws_pkg::ACT_READ)
    else $error("result raised outside a read request");
`endif

endmodule

`default_nettype wire
